@@ hdl/request_line_parser_macros.svh @@
// Assertion macros used by the request line parser RTL
`ifndef REQUEST_LINE_PARSER_MACROS_SVH
`define REQUEST_LINE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define RLP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define RLP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rlp_pkg.sv @@
// Types and constants of the request line parser
`timescale 1ns / 1ps

package rlp_pkg;

  localparam int unsigned CHAR_W = 21;
  localparam int unsigned ACC_W  = 16;
  localparam int unsigned VER_W  = 15;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH = 2'd2;

  // Item kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Commands
  localparam logic CMD_FOF    = 1'b0;
  localparam logic CMD_ISSING = 1'b1;

  // Character codes (upper case letters; lower case is +0x20)
  localparam logic [CHAR_W-1:0] CH_M     = 21'h4D;
  localparam logic [CHAR_W-1:0] CH_P     = 21'h50;
  localparam logic [CHAR_W-1:0] CH_SLASH = 21'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 21'h2E;
  localparam logic [CHAR_W-1:0] CH_O     = 21'h4F;
  localparam logic [CHAR_W-1:0] CH_F     = 21'h46;
  localparam logic [CHAR_W-1:0] CH_S     = 21'h53;
  localparam logic [CHAR_W-1:0] CH_I     = 21'h49;
  localparam logic [CHAR_W-1:0] CH_N     = 21'h4E;
  localparam logic [CHAR_W-1:0] CH_G     = 21'h47;
  localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 21'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 21'h39;
  localparam logic [CHAR_W-1:0] CASE_OFS = 21'h20;

  typedef enum logic [4:0] {
    ST_M      = 5'd0,
    ST_P1     = 5'd1,
    ST_P2     = 5'd2,
    ST_SLASH  = 5'd3,
    ST_MAJOR  = 5'd4,
    ST_MINOR  = 5'd5,
    ST_PATCH  = 5'd6,
    ST_VERB   = 5'd7,
    ST_FOF_O  = 5'd8,
    ST_FOF_F  = 5'd9,
    ST_IS_S1  = 5'd10,
    ST_IS_S2  = 5'd11,
    ST_IS_I2  = 5'd12,
    ST_IS_N   = 5'd13,
    ST_IS_G   = 5'd14,
    ST_SPACE  = 5'd15,
    ST_HEADER = 5'd16
  } rlp_state_e;

  typedef enum logic [REASON_W-1:0] {
    WHY_NONE   = 3'd0,
    WHY_BADREQ = 3'd1,
    WHY_MAJOR  = 3'd2,
    WHY_MINOR  = 3'd3,
    WHY_PATCH  = 3'd4,
    WHY_VERB   = 3'd5
  } rlp_reason_e;

endpackage

@@ hdl/rlp_req_if.sv @@
// Input channel: one character or restart item
`timescale 1ns / 1ps

interface rlp_req_if import rlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, kind, char_code, input ready);
  modport sink   (input valid, kind, char_code, output ready);
endinterface

// Output channel: one parse result item
interface rlp_rsp_if import rlp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                status;
  logic [REASON_W-1:0] fail_reason;
  logic                command_valid;
  logic                command;

  modport source (output valid, status, fail_reason, command_valid, command, input ready);
  modport sink   (input valid, status, fail_reason, command_valid, command, output ready);
endinterface

@@ hdl/request_line_parser.sv @@
// Request line parser top level: input register, parse step, result register
`timescale 1ns / 1ps
`include "request_line_parser_macros.svh"

// Request line parser. Takes one item per clock unless the result side stalls:
// a character of the request line (protocol name, slash, major.minor.patch,
// whitespace, verb FOF or ISSING in any case, whitespace) or a restart. Every
// item gives exactly one result: need-more, or malformed with a reason code;
// the whitespace after the verb also reports the command. Throughput is one
// item per cycle while results are taken, set by the parse state and number
// accumulator, which update once per item. An accepted item is held in the
// input register; its result is loaded into the result register once that is
// free and offered from then on. While the result is held off, the input
// register keeps one more item and the input then stalls. The user is to write
// the version registers through the cfg port only while no item is in flight;
// the block does not enforce this. After reset major is 1, the rest 0.
module request_line_parser import rlp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VER_W-1:0]     cfg_data_i,
  rlp_req_if.sink              req_i,
  rlp_rsp_if.source            rsp_o
);

  // Configuration registers
  logic [VER_W-1:0] exp_major_q, exp_minor_q, exp_patch_q;

  // Input register
  logic              in_valid_q;
  logic              in_kind_q;
  logic [CHAR_W-1:0] in_char_q;

  // Parser state
  rlp_state_e       state_q, state_d;
  logic             issing_q, issing_d;
  logic [ACC_W-1:0] acc_q, acc_d;

  // Result register
  logic                out_valid_q;
  logic                out_status_q, out_status_d;
  logic [REASON_W-1:0] out_reason_q;
  logic                out_cmd_valid_q, out_cmd_valid_d;
  logic                out_cmd_q, out_cmd_d;

  rlp_reason_e why;
  logic        out_free;
  logic        step;
  logic        in_take;

  // Character classes and helpers
  logic             is_digit, is_space, num_ok, num_end;
  logic [ACC_W+3:0] acc_next;
  logic [ACC_W-1:0] acc_sat;
  logic [ACC_W-1:0] num_exp;
  rlp_reason_e      num_why;
  rlp_state_e       num_next;

  function automatic logic letter_is(logic [CHAR_W-1:0] c, logic [CHAR_W-1:0] up);
    return (c == up) || (c == up + CASE_OFS);
  endfunction

  // Handshake
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign step        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;
  assign in_take     = req_i.valid && req_i.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_major_q <= VER_W'(1);
      exp_minor_q <= '0;
      exp_patch_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAJOR: exp_major_q <= cfg_data_i;
        CFG_MINOR: exp_minor_q <= cfg_data_i;
        CFG_PATCH: exp_patch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= req_i.kind;
      in_char_q <= req_i.char_code;
    end
  end

  // Character classes, ASCII only
  assign is_digit = (in_char_q >= CH_ZERO) && (in_char_q <= CH_NINE);
  assign is_space = (in_char_q == CH_SPACE) || ((in_char_q >= CH_TAB) && (in_char_q <= CH_CR));

  // Saturating acc * 10 + digit; the low nibble of an ASCII digit is its value
  assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                    + (ACC_W+4)'(in_char_q[3:0]);
  assign acc_sat  = (|acc_next[ACC_W+3:ACC_W]) ? '1 : acc_next[ACC_W-1:0];

  // Number field terminator and compare, per version field
  always_comb begin
    num_end  = 1'b0;
    num_exp  = '0;
    num_why  = WHY_BADREQ;
    num_next = state_q;
    case (state_q)
      ST_MAJOR: begin
        num_end  = (in_char_q == CH_DOT);
        num_exp  = {1'b0, exp_major_q};
        num_why  = WHY_MAJOR;
        num_next = ST_MINOR;
      end
      ST_MINOR: begin
        num_end  = (in_char_q == CH_DOT);
        num_exp  = {1'b0, exp_minor_q};
        num_why  = WHY_MINOR;
        num_next = ST_PATCH;
      end
      ST_PATCH: begin
        num_end  = is_space;
        num_exp  = {1'b0, exp_patch_q};
        num_why  = WHY_PATCH;
        num_next = ST_VERB;
      end
      default: ;
    endcase
  end

  assign num_ok = (acc_q == num_exp);

  // Next state of the parser (used only on an item that is a character)
  always_comb begin
    state_d  = state_q;
    issing_d = issing_q;
    acc_d    = acc_q;
    unique case (state_q)
      ST_M:     if (in_char_q == CH_M) state_d = ST_P1;
      ST_P1:    if (in_char_q == CH_P) state_d = ST_P2;
      ST_P2:    if (in_char_q == CH_P) state_d = ST_SLASH;
      ST_SLASH: begin
        if (in_char_q == CH_SLASH) begin
          state_d = ST_MAJOR;
          acc_d   = '0;
        end
      end
      ST_MAJOR, ST_MINOR, ST_PATCH: begin
        if (is_digit) begin
          acc_d = acc_sat;
        end else if (num_end && num_ok) begin
          acc_d   = '0;
          state_d = num_next;
        end
      end
      ST_VERB: begin
        if (letter_is(in_char_q, CH_F)) begin
          issing_d = CMD_FOF;
          state_d  = ST_FOF_O;
        end else if (letter_is(in_char_q, CH_I)) begin
          issing_d = CMD_ISSING;
          state_d  = ST_IS_S1;
        end
      end
      ST_FOF_O: if (letter_is(in_char_q, CH_O)) state_d = ST_FOF_F;
      ST_FOF_F: if (letter_is(in_char_q, CH_F)) state_d = ST_SPACE;
      ST_IS_S1: if (letter_is(in_char_q, CH_S)) state_d = ST_IS_S2;
      ST_IS_S2: if (letter_is(in_char_q, CH_S)) state_d = ST_IS_I2;
      ST_IS_I2: if (letter_is(in_char_q, CH_I)) state_d = ST_IS_N;
      ST_IS_N:  if (letter_is(in_char_q, CH_N)) state_d = ST_IS_G;
      ST_IS_G:  if (letter_is(in_char_q, CH_G)) state_d = ST_SPACE;
      ST_SPACE: if (is_space) state_d = ST_HEADER;
      default: ;
    endcase
    // An error leaves the parser untouched
    if (why != WHY_NONE) begin
      state_d  = state_q;
      issing_d = issing_q;
      acc_d    = acc_q;
    end
  end

  // Result of the current character
  always_comb begin
    why             = WHY_NONE;
    out_cmd_valid_d = 1'b0;
    out_cmd_d       = CMD_FOF;
    unique case (state_q)
      ST_M:     if (in_char_q != CH_M) why = WHY_BADREQ;
      ST_P1:    if (in_char_q != CH_P) why = WHY_BADREQ;
      ST_P2:    if (in_char_q != CH_P) why = WHY_BADREQ;
      ST_SLASH: if (in_char_q != CH_SLASH) why = WHY_BADREQ;
      ST_MAJOR, ST_MINOR, ST_PATCH: begin
        if (is_digit) why = WHY_NONE;
        else if (num_end) why = num_ok ? WHY_NONE : num_why;
        else why = WHY_BADREQ;
      end
      ST_VERB: begin
        if (!letter_is(in_char_q, CH_F) && !letter_is(in_char_q, CH_I)) why = WHY_VERB;
      end
      ST_FOF_O: if (!letter_is(in_char_q, CH_O)) why = WHY_BADREQ;
      ST_FOF_F: if (!letter_is(in_char_q, CH_F)) why = WHY_BADREQ;
      ST_IS_S1: if (!letter_is(in_char_q, CH_S)) why = WHY_BADREQ;
      ST_IS_S2: if (!letter_is(in_char_q, CH_S)) why = WHY_BADREQ;
      ST_IS_I2: if (!letter_is(in_char_q, CH_I)) why = WHY_BADREQ;
      ST_IS_N:  if (!letter_is(in_char_q, CH_N)) why = WHY_BADREQ;
      ST_IS_G:  if (!letter_is(in_char_q, CH_G)) why = WHY_BADREQ;
      ST_SPACE: begin
        if (is_space) begin
          out_cmd_valid_d = 1'b1;
          out_cmd_d       = issing_q;
        end else begin
          why = WHY_BADREQ;
        end
      end
      default: ;
    endcase
    // A restart always answers need-more
    if (in_kind_q == KIND_RESTART) begin
      why             = WHY_NONE;
      out_cmd_valid_d = 1'b0;
      out_cmd_d       = CMD_FOF;
    end
    out_status_d = (why != WHY_NONE);
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_M;
      issing_q <= 1'b0;
      acc_q    <= '0;
    end else if (step) begin
      if (in_kind_q == KIND_RESTART) begin
        state_q  <= ST_M;
        issing_q <= 1'b0;
        acc_q    <= '0;
      end else begin
        state_q  <= state_d;
        issing_q <= issing_d;
        acc_q    <= acc_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_status_q    <= out_status_d;
      out_reason_q    <= why;
      out_cmd_valid_q <= out_cmd_valid_d;
      out_cmd_q       <= out_cmd_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.fail_reason   = out_reason_q;
  assign rsp_o.command_valid = out_cmd_valid_q;
  assign rsp_o.command       = out_cmd_q;

  // Checks
  `RLP_ASSERT_IMPL(a_status_reason, rsp_o.valid,
                   rsp_o.status == (rsp_o.fail_reason != WHY_NONE),
                   "status and fail reason disagree")
  `RLP_ASSERT_IMPL(a_cmd_no_err, rsp_o.valid && rsp_o.command_valid, !rsp_o.status,
                   "command reported with an error")
  `RLP_ASSERT_NEXT(a_err_holds, step && in_kind_q == KIND_CHAR && why != WHY_NONE,
                   $stable(state_q) && $stable(acc_q) && $stable(issing_q),
                   "parser state moved on an error")
  `RLP_ASSERT_NEXT(a_cmd_header, step && in_kind_q == KIND_CHAR && out_cmd_valid_d,
                   state_q == ST_HEADER,
                   "command reported without entering the header state")
  `RLP_ASSERT_NEXT(a_restart_clears, step && in_kind_q == KIND_RESTART,
                   state_q == ST_M && acc_q == '0 && !issing_q,
                   "restart did not clear the parser")

endmodule

@@ sim/tb_request_line_parser.sv @@
// Self-checking testbench for the request line parser
`timescale 1ns / 1ps

module tb_request_line_parser import rlp_pkg::*; ();

  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned VER_MAX     = 32767;
  localparam int unsigned ACC_MAX     = 65535;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 21'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 21'h5A;
  localparam logic [CHAR_W-1:0] CH_CODE_MAX = 21'h10FFFF;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] code;
  } stim_t;

  typedef struct packed {
    logic        status;
    rlp_reason_e reason;
    logic        cmd_valid;
    logic        cmd;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MAJOR;
  logic [VER_W-1:0] cfg_data = '0;

  rlp_req_if req_ch ();
  rlp_rsp_if rsp_ch ();

  request_line_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  always #2 clk = ~clk;

  // Predictor state and its copy of the version registers
  rlp_state_e       prs_state  = ST_M;
  logic             prs_issing = 1'b0;
  logic [ACC_W-1:0] prs_acc    = '0;
  rlp_reason_e      prs_last   = WHY_NONE;
  logic [VER_W-1:0] want_major = 15'd1;
  logic [VER_W-1:0] want_minor = 15'd0;
  logic [VER_W-1:0] want_patch = 15'd0;

  answer_t pending_answers[$];

  // Run control and bookkeeping
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned n_items = 0;
  int unsigned n_requests = 0;
  int unsigned n_settings = 0;
  int unsigned n_checked = 0;
  int unsigned n_commands = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_digit(logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_ws(logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_alpha(logic [CHAR_W-1:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_UPPER_A + CASE_OFS && c <= CH_UPPER_Z + CASE_OFS);
  endfunction

  function automatic logic [CHAR_W-1:0] upcase(logic [CHAR_W-1:0] c);
    return (c >= CH_UPPER_A + CASE_OFS && c <= CH_UPPER_Z + CASE_OFS) ? c - CASE_OFS : c;
  endfunction

  function automatic void add_digit(logic [CHAR_W-1:0] c);
    int unsigned sum;
    sum = int'(prs_acc) * 10 + int'(c - CH_ZERO);
    prs_acc = (sum > ACC_MAX) ? '1 : sum[ACC_W-1:0];
  endfunction

  // Version field terminator: compare, then clear and move on
  function automatic rlp_reason_e close_field(logic [VER_W-1:0] want, rlp_reason_e bad,
                                              rlp_state_e nxt);
    if (prs_acc != {1'b0, want}) return bad;
    prs_acc = '0;
    prs_state = nxt;
    return WHY_NONE;
  endfunction

  function automatic rlp_reason_e take_letter(logic [CHAR_W-1:0] c, logic [CHAR_W-1:0] want,
                                              rlp_state_e nxt);
    if (upcase(c) != want) return WHY_BADREQ;
    prs_state = nxt;
    return WHY_NONE;
  endfunction

  // One parse step: advances the predictor and gives the expected answer
  function automatic answer_t parse_char(logic kind, logic [CHAR_W-1:0] c);
    answer_t a;
    rlp_reason_e why;
    why = WHY_NONE;
    a = '0;
    if (kind == KIND_RESTART) begin
      prs_state = ST_M;
      prs_issing = 1'b0;
      prs_acc = '0;
      prs_last = WHY_NONE;
    end else begin
      case (prs_state)
        ST_M: begin
          if (c == CH_M) prs_state = ST_P1; else why = WHY_BADREQ;
        end
        ST_P1: begin
          if (c == CH_P) prs_state = ST_P2; else why = WHY_BADREQ;
        end
        ST_P2: begin
          if (c == CH_P) prs_state = ST_SLASH; else why = WHY_BADREQ;
        end
        ST_SLASH: begin
          if (c == CH_SLASH) begin
            prs_state = ST_MAJOR;
            prs_acc = '0;
          end else begin
            why = WHY_BADREQ;
          end
        end
        ST_MAJOR: begin
          if (is_digit(c)) add_digit(c);
          else if (c == CH_DOT) why = close_field(want_major, WHY_MAJOR, ST_MINOR);
          else why = WHY_BADREQ;
        end
        ST_MINOR: begin
          if (is_digit(c)) add_digit(c);
          else if (c == CH_DOT) why = close_field(want_minor, WHY_MINOR, ST_PATCH);
          else why = WHY_BADREQ;
        end
        ST_PATCH: begin
          if (is_digit(c)) add_digit(c);
          else if (is_ws(c)) why = close_field(want_patch, WHY_PATCH, ST_VERB);
          else why = WHY_BADREQ;
        end
        ST_VERB: begin
          if (is_alpha(c) && upcase(c) == CH_F) begin
            prs_issing = 1'b0;
            prs_state = ST_FOF_O;
          end else if (is_alpha(c) && upcase(c) == CH_I) begin
            prs_issing = 1'b1;
            prs_state = ST_IS_S1;
          end else begin
            why = WHY_VERB;
          end
        end
        ST_FOF_O: why = take_letter(c, CH_O, ST_FOF_F);
        ST_FOF_F: why = take_letter(c, CH_F, ST_SPACE);
        ST_IS_S1: why = take_letter(c, CH_S, ST_IS_S2);
        ST_IS_S2: why = take_letter(c, CH_S, ST_IS_I2);
        ST_IS_I2: why = take_letter(c, CH_I, ST_IS_N);
        ST_IS_N:  why = take_letter(c, CH_N, ST_IS_G);
        ST_IS_G:  why = take_letter(c, CH_G, ST_SPACE);
        ST_SPACE: begin
          if (is_ws(c)) begin
            a.cmd_valid = 1'b1;
            a.cmd = prs_issing ? CMD_ISSING : CMD_FOF;
            prs_state = ST_HEADER;
          end else begin
            why = WHY_BADREQ;
          end
        end
        default: ;  // header: nothing to do
      endcase
      if (why != WHY_NONE) prs_last = why;
    end
    a.status = (why != WHY_NONE);
    a.reason = why;
    return a;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic stim_t ch_item(logic [CHAR_W-1:0] c);
    return '{kind: KIND_CHAR, code: c};
  endfunction

  function automatic stim_t restart_item();
    return '{kind: KIND_RESTART, code: CHAR_W'($urandom_range(0, CH_CODE_MAX))};
  endfunction

  function automatic logic [CHAR_W-1:0] any_case(logic [CHAR_W-1:0] c);
    return $urandom_range(0, 1) ? c + CASE_OFS : c;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_ws();
    int unsigned k;
    k = $urandom_range(0, 6);
    return (k < 5) ? CHAR_W'(CH_TAB + k) : CH_SPACE;
  endfunction

  // Mostly ASCII, some syntax characters, some wide code points
  function automatic logic [CHAR_W-1:0] rand_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return CHAR_W'($urandom_range(0, 127));
    if (r < 80) begin
      case ($urandom_range(0, 8))
        0: return CHAR_W'(CH_ZERO + $urandom_range(0, 9));
        1: return CH_DOT;
        2: return CH_SLASH;
        3: return pick_ws();
        4: return any_case(CH_F);
        5: return any_case(CH_I);
        6: return CH_M;
        7: return CH_P;
        default: return CH_CODE_MAX;
      endcase
    end
    if (r < 90) return CHAR_W'($urandom_range(0, CH_CODE_MAX));
    // wide code point whose low byte looks like ASCII
    return CHAR_W'(($urandom_range(1, 16'h10FF) << 8) | $urandom_range(0, 127));
  endfunction

  // Offer one item, wait for acceptance, record what it should produce
  task automatic send_item(input stim_t it);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 99) < 25) begin
      gap = gap_len();
      req_ch.valid <= 1'b0;
      req_ch.kind <= 1'($urandom_range(0, 1));
      req_ch.char_code <= rand_code();
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= it.kind;
    req_ch.char_code <= it.code;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_answers.push_back(parse_char(it.kind, it.code));
    n_items++;
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c);
    send_item(ch_item(c));
  endtask

  // Stop offering and wait until every expected answer has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_versions(input logic [VER_W-1:0] maj, input logic [VER_W-1:0] mnr,
                              input logic [VER_W-1:0] pat);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MAJOR;
    cfg_data <= maj;
    @(posedge clk);
    cfg_idx <= CFG_MINOR;
    cfg_data <= mnr;
    @(posedge clk);
    cfg_idx <= CFG_PATCH;
    cfg_data <= pat;
    @(posedge clk);
    cfg_we <= 1'b0;
    want_major = maj;
    want_minor = mnr;
    want_patch = pat;
    n_settings++;
  endtask

  // Decimal field: usually the wanted value, sometimes wrong or saturating
  task automatic add_field(ref stim_t q[$], input logic [VER_W-1:0] want);
    int unsigned r;
    int unsigned v;
    int unsigned digits[$];
    r = $urandom_range(0, 99);
    if (r >= 96) begin
      repeat ($urandom_range(6, 9)) q.push_back(ch_item(CH_NINE));
      return;
    end
    v = (r < 85) ? want : (r < 92) ? $urandom_range(0, VER_MAX) : want + 1;
    if (v == 0 && $urandom_range(0, 1)) return;
    if ($urandom_range(0, 3) == 0) q.push_back(ch_item(CH_ZERO));
    do begin
      digits.push_front(v % 10);
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) q.push_back(ch_item(CHAR_W'(CH_ZERO + digits[i])));
  endtask

  // A request line with random content, now and then damaged
  task automatic send_request();
    stim_t line_q[$];
    int unsigned pos;
    if ($urandom_range(0, 9) != 0) line_q.push_back(restart_item());
    line_q.push_back(ch_item(CH_M));
    line_q.push_back(ch_item(CH_P));
    line_q.push_back(ch_item(CH_P));
    line_q.push_back(ch_item(CH_SLASH));
    add_field(line_q, want_major);
    line_q.push_back(ch_item(CH_DOT));
    add_field(line_q, want_minor);
    line_q.push_back(ch_item(CH_DOT));
    add_field(line_q, want_patch);
    line_q.push_back(ch_item(pick_ws()));
    if ($urandom_range(0, 1)) begin
      line_q.push_back(ch_item(any_case(CH_I)));
      line_q.push_back(ch_item(any_case(CH_S)));
      line_q.push_back(ch_item(any_case(CH_S)));
      line_q.push_back(ch_item(any_case(CH_I)));
      line_q.push_back(ch_item(any_case(CH_N)));
      line_q.push_back(ch_item(any_case(CH_G)));
    end else begin
      line_q.push_back(ch_item(any_case(CH_F)));
      line_q.push_back(ch_item(any_case(CH_O)));
      line_q.push_back(ch_item(any_case(CH_F)));
    end
    line_q.push_back(ch_item(pick_ws()));
    repeat ($urandom_range(0, 2)) line_q.push_back(ch_item(rand_code()));
    if ($urandom_range(0, 99) < 20) begin
      pos = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(0, 3))
        0: line_q[pos] = ch_item(rand_code());
        1: line_q.insert(pos, ch_item(rand_code()));
        2: line_q.insert(pos, restart_item());
        default: while (line_q.size() > pos) void'(line_q.pop_back());
      endcase
    end
    foreach (line_q[i]) send_item(line_q[i]);
    n_requests++;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 12)) begin
      if ($urandom_range(0, 9) == 0) send_item(restart_item());
      else send_char(rand_code());
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Restart, protocol name, bad slash, empty minor and patch, bad verb start,
  // wide code point inside the verb, mixed case ISSING, then the header state
  task automatic test_walkthrough();
    send_item(restart_item());
    send_char(CH_M);
    send_char(CH_P);
    send_char(CH_P);
    send_char(21'h78);
    send_char(CH_SLASH);
    send_char(CH_ZERO + 21'd1);
    send_char(CH_DOT);
    send_char(CH_DOT);
    send_char(CH_SPACE);
    send_char(CH_ZERO + 21'd7);
    send_char(CH_I + CASE_OFS);
    send_char(CH_S + CASE_OFS);
    send_char(CH_S);
    send_char(CH_CODE_MAX);
    send_char(CH_I + CASE_OFS);
    send_char(CH_N);
    send_char(CH_G + CASE_OFS);
    send_char(CH_CR);
    send_char(CH_UPPER_A);
  endtask

  // Empty major against a non-zero register, then a wrong minor
  task automatic test_bad_versions();
    send_item(restart_item());
    send_char(CH_M);
    send_char(CH_P);
    send_char(CH_P);
    send_char(CH_SLASH);
    send_char(CH_DOT);
    send_char(CH_ZERO + 21'd1);
    send_char(CH_DOT);
    send_char(CH_ZERO + 21'd5);
    send_char(CH_DOT);
  endtask

  task automatic test_reset_settings();
    repeat (15) send_request();
  endtask

  // Output held off for a long stretch while input keeps coming
  task automatic test_output_hold();
    tx_idle_en = 1'b0;
    hold_len <= HOLD_CYCLES;
    hold_seq <= hold_seq + 1;
    repeat (3) send_request();
    tx_idle_en = 1'b1;
  endtask

  // Register extremes, run back to back without idling
  task automatic test_register_extremes();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    set_versions(VER_W'(VER_MAX), VER_W'(VER_MAX), VER_W'(VER_MAX));
    repeat (8) send_request();
    set_versions('0, '0, '0);
    repeat (8) send_request();
    set_versions('0, VER_W'(VER_MAX), '0);
    repeat (4) send_request();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_random_settings();
    logic [VER_W-1:0] v[3];
    while (n_items < ITEM_TARGET) begin
      foreach (v[i]) v[i] = ($urandom_range(0, 3) == 0) ? VER_W'($urandom_range(0, VER_MAX))
                                                        : VER_W'($urandom_range(0, 12));
      set_versions(v[0], v[1], v[2]);
      repeat (6) begin
        if ($urandom_range(0, 99) < 12) send_noise();
        else send_request();
      end
    end
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    answer_t     exp_a;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (pending_answers.size() == 0) begin
          $error("result with no item outstanding");
          n_errors++;
        end else begin
          exp_a = pending_answers.pop_front();
          n_checked++;
          if (rsp_ch.status !== exp_a.status) begin
            $error("status: expected %0d, actual %0d", exp_a.status, rsp_ch.status);
            n_errors++;
          end
          if (rsp_ch.fail_reason !== exp_a.reason) begin
            $error("fail_reason: expected %0d, actual %0d", exp_a.reason, rsp_ch.fail_reason);
            n_errors++;
          end
          if (rsp_ch.command_valid !== exp_a.cmd_valid) begin
            $error("command_valid: expected %0d, actual %0d", exp_a.cmd_valid,
                   rsp_ch.command_valid);
            n_errors++;
          end
          if (rsp_ch.command !== exp_a.cmd) begin
            $error("command: expected %0d, actual %0d", exp_a.cmd, rsp_ch.command);
            n_errors++;
          end
          if (exp_a.cmd_valid) n_commands++;
        end
      end
      // ready: long hold-off on request, else random stalls
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
        stall_left = gap_len() - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_CHAR;
    req_ch.char_code <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_idle_en <= 1'b1;

    test_walkthrough();
    test_bad_versions();
    test_reset_settings();
    test_output_hold();
    test_register_extremes();
    test_random_settings();

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d items in %0d request lines under %0d register settings,",
             n_items, n_requests, n_settings);
    $display("with %0d results checked, %0d command reports and a %0d-cycle output hold-off.",
             n_checked, n_commands, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
